// File: src/bgs_pkg.sv
// Shared types and constants for the bilinear gray sampler.
// Payload structs, opcode and register codes, gray weights and datapath widths.
// No dependencies.
package bgs_pkg;

  localparam int SAMPLE_W   = 20;
  localparam int CFG_DATA_W = 11;
  localparam int GRAY_Q_W   = 24;  // Q8.16 gray level of one pixel
  localparam int GRAY_FRAC  = 16;

  // Blend datapath widths, good for any fraction width up to 16 bits
  localparam int A_W   = 45;  // one row-axis blend
  localparam int D_W   = 46;  // difference of two row-axis blends
  localparam int SPLIT = 23;  // low half of the difference in the split product
  localparam int P_W   = 66;  // full column-axis product
  localparam int PS_W  = 64;  // product after the magnitude limit
  localparam int V_W   = 65;  // final blend

  localparam logic [63:0] PROD_LIMIT = 64'h4000_0000_0000_0000;

  localparam logic [15:0] W_BLUE  = 16'd7209;
  localparam logic [15:0] W_GREEN = 16'd38666;
  localparam logic [15:0] W_RED   = 16'd19661;

  localparam logic [7:0] GRAY_MAX = 8'hFF;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic REG_IMAGE_ROWS = 1'b0;
  localparam logic REG_IMAGE_COLS = 1'b1;

  localparam logic [9:0]  ROWS_RESET = 10'd480;
  localparam logic [10:0] COLS_RESET = 11'd640;

  typedef struct packed {
    logic                       opcode;
    logic [8:0]                 pixel_row;
    logic [9:0]                 pixel_col;
    logic [7:0]                 pixel_blue;
    logic [7:0]                 pixel_green;
    logic [7:0]                 pixel_red;
    logic signed [SAMPLE_W-1:0] sample_row;
    logic signed [SAMPLE_W-1:0] sample_col;
    logic [9:0]                 dest_row;
    logic [9:0]                 dest_col;
  } in_t;

  typedef struct packed {
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic [7:0] gray_value;
  } out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic sample;
    logic write;
  } ctl_t;

  typedef struct packed {
    logic r0;
    logic r1;
    logic c0;
    logic c1;
  } par_t;

  typedef struct packed {
    logic [9:0]                 dest_row;
    logic [9:0]                 dest_col;
    logic signed [SAMPLE_W-1:0] frac_row;
    logic signed [SAMPLE_W-1:0] frac_col;
  } side_t;

endpackage

// File: src/bgs_front.sv
// Input stage: neighbour indices, clamping and fractions, or the write address.
// Depends on bgs_pkg.
module bgs_front
  import bgs_pkg::*;
#(
  parameter int MAX_ROWS  = 512,
  parameter int MAX_COLS  = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  in_t                         in_data,
  input  logic [$clog2(MAX_ROWS)-1:0] row_lim,
  input  logic [$clog2(MAX_COLS)-1:0] col_lim,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ctl_t                        out_ctl,
  output logic [$clog2(MAX_ROWS)-1:0] row0,
  output logic [$clog2(MAX_ROWS)-1:0] row1,
  output logic [$clog2(MAX_COLS)-1:0] col0,
  output logic [$clog2(MAX_COLS)-1:0] col1,
  output pix_t                        out_pix,
  output side_t                       out_side
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam logic signed [SAMPLE_W:0] ONE = (SAMPLE_W + 1)'(1) << FRAC_BITS;

  function automatic logic [31:0] clamp_idx(input logic signed [SAMPLE_W:0] v,
                                            input logic [31:0] lim);
    logic [31:0] t;
    t = 32'(v >>> FRAC_BITS);
    if (v < 0) t = '0;
    else if (t > lim) t = lim;
    return t;
  endfunction

  logic signed [SAMPLE_W:0]   sr, sc, sr1, sc1;
  logic [RW-1:0]              row0_next, row1_next;
  logic [CW-1:0]              col0_next, col1_next;
  logic signed [SAMPLE_W-1:0] dr_next, dc_next;
  ctl_t                       ctl_next;

  always_comb begin
    sr  = (SAMPLE_W + 1)'(in_data.sample_row);
    sc  = (SAMPLE_W + 1)'(in_data.sample_col);
    sr1 = sr + ONE;
    sc1 = sc + ONE;
    ctl_next.sample = (in_data.opcode == OP_SAMPLE);
    ctl_next.write  = (in_data.opcode == OP_WRITE) &&
                      (32'(in_data.pixel_row) < MAX_ROWS) &&
                      (32'(in_data.pixel_col) < MAX_COLS);
    if (in_data.opcode == OP_WRITE) begin
      row0_next = RW'(in_data.pixel_row);
      row1_next = RW'(in_data.pixel_row);
      col0_next = CW'(in_data.pixel_col);
      col1_next = CW'(in_data.pixel_col);
    end else begin
      row0_next = RW'(clamp_idx(sr, 32'(row_lim)));
      row1_next = RW'(clamp_idx(sr1, 32'(row_lim)));
      col0_next = CW'(clamp_idx(sc, 32'(col_lim)));
      col1_next = CW'(clamp_idx(sc1, 32'(col_lim)));
    end
    // sample minus clamped integer part always fits the sample width
    dr_next = SAMPLE_W'(32'(sr) - (32'(row0_next) << FRAC_BITS));
    dc_next = SAMPLE_W'(32'(sc) - (32'(col0_next) << FRAC_BITS));
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_ctl           <= ctl_next;
      row0              <= row0_next;
      row1              <= row1_next;
      col0              <= col0_next;
      col1              <= col1_next;
      out_pix.red       <= in_data.pixel_red;
      out_pix.green     <= in_data.pixel_green;
      out_pix.blue      <= in_data.pixel_blue;
      out_side.dest_row <= in_data.dest_row;
      out_side.dest_col <= in_data.dest_col;
      out_side.frac_row <= dr_next;
      out_side.frac_col <= dc_next;
    end
  end

endmodule

// File: src/bgs_store.sv
// Image store in four row/column parity banks, one single-port RAM each.
// Reads all four neighbours in one read; depends on bgs_pkg.
module bgs_store
  import bgs_pkg::*;
#(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ctl_t                        in_ctl,
  input  logic [$clog2(MAX_ROWS)-1:0] row0,
  input  logic [$clog2(MAX_ROWS)-1:0] row1,
  input  logic [$clog2(MAX_COLS)-1:0] col0,
  input  logic [$clog2(MAX_COLS)-1:0] col1,
  input  pix_t                        in_pix,
  input  side_t                       in_side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pix_t                        p00,
  output pix_t                        p10,
  output pix_t                        p01,
  output pix_t                        p11,
  output side_t                       out_side
);

  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int ROWS_H = (MAX_ROWS + 1) / 2;
  localparam int COLS_H = (MAX_COLS + 1) / 2;
  localparam int DEPTH  = ROWS_H * COLS_H;
  localparam int BA_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic pix_t pick(input logic [1:0] s, input pix_t d0, input pix_t d1,
                                input pix_t d2, input pix_t d3);
    pix_t p;
    unique case (s)
      2'b00:   p = d0;
      2'b01:   p = d1;
      2'b10:   p = d2;
      default: p = d3;
    endcase
    return p;
  endfunction

  pix_t bank_data [4];
  par_t par;

  assign in_ready = !out_valid || out_ready;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic RP = 1'((b >> 1) & 1);
    localparam logic CP = 1'(b & 1);

    logic [RW-1:0]   row;
    logic [CW-1:0]   col;
    logic [BA_W-1:0] addr;
    logic            wen;
    pix_t            mem [DEPTH];
    pix_t            rdata;

    // the bank whose parity matches the base index serves it, the other the next one
    assign row  = (row0[0] == RP) ? row0 : row1;
    assign col  = (col0[0] == CP) ? col0 : col1;
    assign addr = BA_W'(((32'(row) >> 1) * COLS_H) + (32'(col) >> 1));
    assign wen  = in_valid && in_ready && in_ctl.write &&
                  (row0[0] == RP) && (col0[0] == CP);

    always_ff @(posedge clk) begin
      if (wen) begin
        mem[addr] <= in_pix;
      end
      if (in_ready) begin
        rdata <= mem[addr];
      end
    end

    assign bank_data[b] = rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid && in_ctl.sample;
    end
    if (in_ready) begin
      par.r0   <= row0[0];
      par.r1   <= row1[0];
      par.c0   <= col0[0];
      par.c1   <= col1[0];
      out_side <= in_side;
    end
  end

  assign p00 = pick({par.r0, par.c0}, bank_data[0], bank_data[1], bank_data[2], bank_data[3]);
  assign p10 = pick({par.r1, par.c0}, bank_data[0], bank_data[1], bank_data[2], bank_data[3]);
  assign p01 = pick({par.r0, par.c1}, bank_data[0], bank_data[1], bank_data[2], bank_data[3]);
  assign p11 = pick({par.r1, par.c1}, bank_data[0], bank_data[1], bank_data[2], bank_data[3]);

endmodule

// File: src/bgs_blend.sv
// Five-stage blend: gray per pixel, row-axis blend, split column product,
// product limit, final blend with saturation. Depends on bgs_pkg.
module bgs_blend
  import bgs_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  pix_t  p00,
  input  pix_t  p10,
  input  pix_t  p01,
  input  pix_t  p11,
  input  side_t in_side,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  localparam int GRAY_SHIFT = 2 * FRAC_BITS + GRAY_FRAC;
  localparam logic signed [P_W-1:0] P_HI = P_W'(PROD_LIMIT);
  localparam logic signed [P_W-1:0] P_LO = -P_HI;

  function automatic logic [GRAY_Q_W-1:0] gray_of(input pix_t p);
    logic [GRAY_Q_W-1:0] b, g, r;
    b = GRAY_Q_W'(p.blue) * GRAY_Q_W'(W_BLUE);
    g = GRAY_Q_W'(p.green) * GRAY_Q_W'(W_GREEN);
    r = GRAY_Q_W'(p.red) * GRAY_Q_W'(W_RED);
    return b + g + r;
  endfunction

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  // stage 1
  logic [GRAY_Q_W-1:0] g00, g10, g01, g11;
  side_t               s1_side;
  // stage 2
  logic signed [A_W-1:0] s2_a0, s2_a1;
  side_t                 s2_side;
  // stage 3
  logic signed [SPLIT+SAMPLE_W-1:0]     s3_ph;
  logic signed [SPLIT+SAMPLE_W:0]       s3_pl;
  logic signed [A_W-1:0]                s3_a0;
  side_t                                s3_side;
  // stage 4
  logic signed [PS_W-1:0] s4_ps;
  logic signed [A_W-1:0]  s4_a0;
  side_t                  s4_side;

  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  logic signed [GRAY_Q_W:0] dr0, dr1;
  logic signed [A_W-1:0]    m0, m1, a0_next, a1_next;
  logic signed [D_W-1:0]    dd;
  logic signed [SPLIT+SAMPLE_W-1:0] ph_next;
  logic signed [SPLIT+SAMPLE_W:0]   pl_next;
  logic signed [P_W-1:0]    prod;
  logic signed [PS_W-1:0]   ps_next;
  logic signed [V_W-1:0]    val;
  logic [V_W-1:0]           q;
  logic [7:0]               gray_next;

  always_comb begin
    // row-axis blend
    dr0     = signed'({1'b0, g10}) - signed'({1'b0, g00});
    dr1     = signed'({1'b0, g11}) - signed'({1'b0, g01});
    m0      = dr0 * signed'(s1_side.frac_row);
    m1      = dr1 * signed'(s1_side.frac_row);
    a0_next = (A_W'(signed'({1'b0, g00})) <<< FRAC_BITS) + m0;
    a1_next = (A_W'(signed'({1'b0, g01})) <<< FRAC_BITS) + m1;
    // column-axis product, cut in two halves
    dd      = D_W'(s2_a1) - D_W'(s2_a0);
    ph_next = signed'(dd[D_W-1:SPLIT]) * signed'(s2_side.frac_col);
    pl_next = signed'({1'b0, dd[SPLIT-1:0]}) * signed'(s2_side.frac_col);
    // recombine and limit the magnitude
    prod = (P_W'(s3_ph) <<< SPLIT) + P_W'(s3_pl);
    if (prod > P_HI) ps_next = PS_W'(P_HI);
    else if (prod < P_LO) ps_next = PS_W'(P_LO);
    else ps_next = PS_W'(prod);
    // final blend, truncate and saturate
    val = (V_W'(s4_a0) <<< FRAC_BITS) + V_W'(s4_ps);
    q   = V_W'(val >>> GRAY_SHIFT);
    if (val < 0) gray_next = '0;
    else if (q > V_W'(GRAY_MAX)) gray_next = GRAY_MAX;
    else gray_next = q[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
    if (en1) begin
      g00     <= gray_of(p00);
      g10     <= gray_of(p10);
      g01     <= gray_of(p01);
      g11     <= gray_of(p11);
      s1_side <= in_side;
    end
    if (en2) begin
      s2_a0   <= a0_next;
      s2_a1   <= a1_next;
      s2_side <= s1_side;
    end
    if (en3) begin
      s3_ph   <= ph_next;
      s3_pl   <= pl_next;
      s3_a0   <= s2_a0;
      s3_side <= s2_side;
    end
    if (en4) begin
      s4_ps   <= ps_next;
      s4_a0   <= s3_a0;
      s4_side <= s3_side;
    end
    if (en5) begin
      out_data.out_row    <= s4_side.dest_row;
      out_data.out_col    <= s4_side.dest_col;
      out_data.gray_value <= gray_next;
    end
  end

endmodule

// File: src/bilinear_gray_sampler_core.sv
// Bilinear gray sampler, top level. Samples pass the front, store and blend stages
// to out_valid; throughput one transaction per cycle while out_ready holds, set by
// the four parity-banked single-port RAMs that give all four neighbours in one read.
// Write transactions leave after the store stage and produce no result.
// rst (synchronous) clears all stage valids and loads 480 rows and 640 columns;
// the image store is not cleared and holds undefined data until written.
module bilinear_gray_sampler_core
  import bgs_pkg::*;
#(
  parameter int MAX_ROWS  = 512,
  parameter int MAX_COLS  = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  // Configuration registers: the user writes them only while the pipeline is drained; not enforced here
  logic [9:0]  image_rows;
  logic [10:0] image_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= ROWS_RESET;
      image_cols <= COLS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_ROWS: image_rows <= cfg_data[9:0];
        REG_IMAGE_COLS: image_cols <= cfg_data;
        default:        image_cols <= image_cols;
      endcase
    end
  end

  // Largest valid index: a size of zero acts as one, an oversize one as the store size
  logic [RW-1:0] row_lim;
  logic [CW-1:0] col_lim;

  always_comb begin
    if (image_rows == '0) row_lim = '0;
    else if (32'(image_rows) > MAX_ROWS) row_lim = RW'(MAX_ROWS - 1);
    else row_lim = RW'(32'(image_rows) - 1);
    if (image_cols == '0) col_lim = '0;
    else if (32'(image_cols) > MAX_COLS) col_lim = CW'(MAX_COLS - 1);
    else col_lim = CW'(32'(image_cols) - 1);
  end

  // Front stage: clamp indices, derive fractions, or decode the write address
  logic          front_valid;
  logic          store_ready;
  ctl_t          front_ctl;
  logic [RW-1:0] row0, row1;
  logic [CW-1:0] col0, col1;
  pix_t          front_pix;
  side_t         front_side;

  bgs_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .row_lim  (row_lim),
    .col_lim  (col_lim),
    .out_valid(front_valid),
    .out_ready(store_ready),
    .out_ctl  (front_ctl),
    .row0     (row0),
    .row1     (row1),
    .col0     (col0),
    .col1     (col1),
    .out_pix  (front_pix),
    .out_side (front_side)
  );

  // Store stage: a write updates one bank, a sample reads all four banks
  logic  store_valid;
  logic  blend_ready;
  pix_t  p00, p10, p01, p11;
  side_t store_side;

  bgs_store #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .in_ready (store_ready),
    .in_ctl   (front_ctl),
    .row0     (row0),
    .row1     (row1),
    .col0     (col0),
    .col1     (col1),
    .in_pix   (front_pix),
    .in_side  (front_side),
    .out_valid(store_valid),
    .out_ready(blend_ready),
    .p00      (p00),
    .p10      (p10),
    .p01      (p01),
    .p11      (p11),
    .out_side (store_side)
  );

  // Blend stages; the last one is the output register
  bgs_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk      (clk),
    .rst      (rst),
    .in_valid (store_valid),
    .in_ready (blend_ready),
    .p00      (p00),
    .p10      (p10),
    .p01      (p01),
    .p11      (p11),
    .in_side  (store_side),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // An empty output register lets every stage advance
  a_ready_when_drained : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  // An accepted sample transaction lands in the front stage as a sample
  a_sample_enters : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.opcode == OP_SAMPLE) |=>
    (front_valid && front_ctl.sample))
    else $error("sample transaction lost at the front stage");

  // A write transaction ends at the store and never reaches the blend stages
  a_write_drops : assert property (@(posedge clk) disable iff (rst)
    (front_valid && store_ready && front_ctl.write) |=> !store_valid)
    else $error("write transaction passed the store stage");

endmodule

// File: dv/bilinear_gray_sampler_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for bilinear_gray_sampler_core: pixel writes and bilinear
// gray samples over many image sizes, scored against an in-bench blend predictor.
// Depends on bgs_pkg and the core RTL only.
module bilinear_gray_sampler_core_test
  import bgs_pkg::*;
();

  localparam int MAX_ROWS = 512;
  localparam int MAX_COLS = 1024;
  localparam int FRAC = 8;
  localparam int ONE = 1 << FRAC;
  localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));
  localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
  // Gray weights in Q0.16 for blue, green and red
  localparam longint WT_BLUE = 7209;
  localparam longint WT_GREEN = 38666;
  localparam longint WT_RED = 19661;
  localparam logic signed [127:0] PROD_CAP = 128'sd1 <<< 62;
  localparam int OPS_PER_SIZE = 96;
  localparam int SETTLE_CYCLES = 16;  // longer than the pipeline
  localparam int CYCLE_LIMIT = 600000;

  // Where a sample lands relative to the image
  typedef enum int {SPOT_NEAR, SPOT_ANY, SPOT_EDGE, SPOT_WILD} spot_e;
  // Back-pressure pattern of the result side
  typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_PULSE, FLOW_RARE_STALL} flow_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_IMAGE_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bilinear_gray_sampler_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Transactions waiting for the driver, and gray results owed by the core
  in_t queued_ops[$];
  out_t pending_grays[$];

  // Predictor state: its own copy of the pixel store and of the size registers
  pix_t shadow_image[int];
  logic [9:0] rows_reg = ROWS_RESET;
  logic [10:0] cols_reg = COLS_RESET;

  // Generator state: pixels already written, size in force, hotspot of the phase
  bit painted[int];
  int gen_rows, gen_cols, hot_r, hot_c;
  int ops_made = 0;
  int fault_count = 0;
  int unsigned cycle_count = 0;

  int gap_left = 0;
  int burst_left = 0;
  flow_e flow = FLOW_FREE;
  int flow_left = 0;

  function automatic int pix_key(int r, int c);
    return r * MAX_COLS + c;
  endfunction

  // A size register of zero acts as one; above the store it acts as the store size
  function automatic int span_of(int unsigned raw, int lim);
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  // Integer part, truncated toward zero
  function automatic longint whole(longint v);
    if (v >= 0) return v >>> FRAC;
    return -((-v) >>> FRAC);
  endfunction

  function automatic int clip(longint v, int hi);
    if (v > hi) v = hi;
    if (v < 0) v = 0;
    return int'(v);
  endfunction

  // Clamped rows and columns of the four neighbours of a sample position
  function automatic void corners(input int sr, input int sc, input int rows, input int cols,
                                  output int r0, output int r1, output int c0, output int c1);
    r0 = clip(whole(sr), rows - 1);
    r1 = clip(whole(sr + ONE), rows - 1);
    c0 = clip(whole(sc), cols - 1);
    c1 = clip(whole(sc + ONE), cols - 1);
  endfunction

  function automatic longint pix_gray(int r, int c);
    pix_t p;
    p = shadow_image[pix_key(r, c)];
    return longint'(p.blue) * WT_BLUE + longint'(p.green) * WT_GREEN
         + longint'(p.red) * WT_RED;
  endfunction

  // Blend along rows in Q(FRAC+16), then along columns in Q(2*FRAC+16)
  function automatic out_t bilinear_gray(in_t op);
    int sr, sc, r0, r1, c0, c1;
    longint dr, dc, g00, g10, g01, g11, a0, a1, val;
    logic signed [127:0] diff_w, frac_w, prod;
    out_t res;
    sr = $signed(op.sample_row);
    sc = $signed(op.sample_col);
    corners(sr, sc, span_of(rows_reg, MAX_ROWS), span_of(cols_reg, MAX_COLS), r0, r1, c0, c1);
    dr = sr - r0 * ONE;
    dc = sc - c0 * ONE;
    g00 = pix_gray(r0, c0);
    g10 = pix_gray(r1, c0);
    g01 = pix_gray(r0, c1);
    g11 = pix_gray(r1, c1);
    a0 = g00 * ONE + (g10 - g00) * dr;
    a1 = g01 * ONE + (g11 - g01) * dr;
    // Hold the column product at 2^62 in magnitude, keeping its sign
    diff_w = a1 - a0;
    frac_w = dc;
    prod = diff_w * frac_w;
    if (prod > PROD_CAP) prod = PROD_CAP;
    else if (prod < -PROD_CAP) prod = -PROD_CAP;
    val = a0 * ONE + longint'(prod[63:0]);
    res.out_row = op.dest_row;
    res.out_col = op.dest_col;
    if (val < 0) res.gray_value = 8'd0;
    else if ((val >>> (2 * FRAC + 16)) > 255) res.gray_value = 8'd255;
    else res.gray_value = val[2*FRAC+23:2*FRAC+16];
    return res;
  endfunction

  task automatic note_fault(string what, longint want, longint got);
    fault_count++;
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (pending_grays.size() == 0) begin
      note_fault("stray result (none pending), gray", -1, got.gray_value);
      return;
    end
    want = pending_grays.pop_front();
    if (got.out_row != want.out_row) note_fault("out_row", want.out_row, got.out_row);
    if (got.out_col != want.out_col) note_fault("out_col", want.out_col, got.out_col);
    if (got.gray_value != want.gray_value)
      note_fault("gray_value", want.gray_value, got.gray_value);
  endtask

  // Random filler for the fields a transaction does not use
  function automatic in_t noise_op();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(in_t)-1:0];
  endfunction

  function automatic logic [7:0] shade();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_write(int r, int c, logic [7:0] b, logic [7:0] g, logic [7:0] rd);
    in_t op;
    op = noise_op();
    op.opcode = OP_WRITE;
    op.pixel_row = 9'(r);
    op.pixel_col = 10'(c);
    op.pixel_blue = b;
    op.pixel_green = g;
    op.pixel_red = rd;
    painted[pix_key(r, c)] = 1'b1;
    queued_ops.push_back(op);
    ops_made++;
  endtask

  // Paint any neighbour not yet written, then queue the sample itself
  task automatic push_sample(int sr, int sc, int dst_r = -1, int dst_c = -1);
    in_t op;
    int rr[2];
    int cc[2];
    corners(sr, sc, gen_rows, gen_cols, rr[0], rr[1], cc[0], cc[1]);
    foreach (rr[i])
      foreach (cc[j])
        if (!painted.exists(pix_key(rr[i], cc[j])))
          push_write(rr[i], cc[j], shade(), shade(), shade());
    op = noise_op();
    op.opcode = OP_SAMPLE;
    op.sample_row = sr[SAMPLE_W-1:0];
    op.sample_col = sc[SAMPLE_W-1:0];
    if (dst_r >= 0) op.dest_row = 10'(dst_r);
    if (dst_c >= 0) op.dest_col = 10'(dst_c);
    queued_ops.push_back(op);
    ops_made++;
  endtask

  // One axis of a sample position: mostly near the hotspot, some across and
  // beyond the image, some at its edges, a few anywhere in the 20-bit range
  function automatic int pick_coord(int span, int hot);
    int roll, base;
    logic [SAMPLE_W-1:0] raw;
    spot_e kind;
    roll = $urandom_range(0, 9);
    if (roll < 5) kind = SPOT_NEAR;
    else if (roll < 7) kind = SPOT_ANY;
    else if (roll < 9) kind = SPOT_EDGE;
    else kind = SPOT_WILD;
    case (kind)
      SPOT_NEAR: return hot * ONE - ONE + int'($urandom_range(0, 6 * ONE));
      SPOT_ANY: return int'($urandom_range(0, (span + 3) * ONE)) - 2 * ONE;
      SPOT_EDGE: begin
        case ($urandom_range(0, 4))
          0: base = -1;
          1: base = 0;
          2: base = span - 2;
          3: base = span - 1;
          default: base = span;
        endcase
        return base * ONE + int'($urandom_range(0, ONE - 1));
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          default: begin
            raw = SAMPLE_W'($urandom);
            return $signed(raw);
          end
        endcase
      end
    endcase
  endfunction

  task automatic random_op();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2)
      push_write($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, MAX_COLS - 1),
                 shade(), shade(), shade());
    else if (roll < 3)
      // repaint around the hotspot so later samples see fresh neighbours
      push_write(clip(hot_r + $urandom_range(0, 5), MAX_ROWS - 1),
                 clip(hot_c + $urandom_range(0, 5), MAX_COLS - 1), shade(), shade(), shade());
    else
      push_sample(pick_coord(gen_rows, hot_r), pick_coord(gen_cols, hot_c));
  endtask

  // Write both size registers on consecutive edges; the core must be idle
  task automatic set_size(logic [CFG_DATA_W-1:0] raw_r, logic [CFG_DATA_W-1:0] raw_c);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_ROWS;
    cfg_data <= raw_r;
    @(posedge clk);
    cfg_index <= REG_IMAGE_COLS;
    cfg_data <= raw_c;
    @(posedge clk);
    cfg_write <= 1'b0;
    gen_rows = span_of(raw_r[9:0], MAX_ROWS);
    gen_cols = span_of(raw_c, MAX_COLS);
  endtask

  // Hold until every queued transaction is taken and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (queued_ops.size() != 0 || in_valid || pending_grays.size() != 0);
  endtask

  // Driver: advance through the queue in bursts of random length with random
  // gaps; a zero gap gives stretches of back-to-back transactions.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_ops.size() != 0) begin
        in_data <= queued_ops.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: switch between free flow, coin-flip stalls, a sparse ready
  // pulse and rare stalls, each for a random stretch of cycles.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      flow_left = 0;
    end else begin
      if (flow_left == 0) begin
        flow = flow_e'($urandom_range(0, 3));
        flow_left = $urandom_range(16, 160);
      end else begin
        flow_left--;
      end
      case (flow)
        FLOW_FREE: out_ready <= 1'b1;
        FLOW_COIN: out_ready <= 1'($urandom_range(0, 1));
        FLOW_PULSE: out_ready <= (flow_left % 5 == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Monitor: track register writes, predict each accepted sample, and score
  // each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_IMAGE_ROWS) rows_reg = cfg_data[9:0];
        else cols_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (in_data.opcode == OP_WRITE)
          shadow_image[pix_key(in_data.pixel_row, in_data.pixel_col)] =
            '{red: in_data.pixel_red, green: in_data.pixel_green, blue: in_data.pixel_blue};
        else
          pending_grays.push_back(bilinear_gray(in_data));
      end
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bilinear_gray_sampler_core: mismatch");
      $finish;
    end
  end

  initial begin
    // Zero and oversize values, 1x1, full store, thin and narrow images
    int unsigned plan_rows [8] = '{0, 1, 11'h7FF, 512, 2, 3, 512, 7};
    int unsigned plan_cols [8] = '{0, 1, 11'h7FF, 1024, 2, 1024, 5, 9};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset size of 480 x 640
    gen_rows = span_of(ROWS_RESET, MAX_ROWS);
    gen_cols = span_of(COLS_RESET, MAX_COLS);
    push_write(0, 0, 8'hFF, 8'hFF, 8'hFF);
    push_write(0, 1, 8'h00, 8'h00, 8'h00);
    push_write(1, 0, 8'hFF, 8'h00, 8'h00);
    push_write(1, 1, 8'h00, 8'h00, 8'hFF);
    push_write(479, 639, 8'h00, 8'hFF, 8'h00);
    push_write(MAX_ROWS - 1, MAX_COLS - 1, 8'hFF, 8'hFF, 8'hFF);  // last store entry
    push_sample(0, 0, 0, 0);
    push_sample(ONE / 2, ONE / 2, 1023, 1023);
    push_sample(ONE - 1, ONE - 1);
    push_sample(-ONE / 2, ONE / 2);  // negative fraction on the row axis
    push_sample(ONE, 0);  // exact integer position
    push_sample(479 * ONE + ONE / 2, 639 * ONE + ONE / 2);  // next row and column clamp
    push_sample(SAMPLE_MAX, SAMPLE_MAX);
    push_sample(SAMPLE_MIN, SAMPLE_MIN);
    push_sample(SAMPLE_MIN, SAMPLE_MAX);

    // Random part: the reset size, the planned sizes, then a few random sizes
    for (int s = 0; s < 13; s++) begin
      if (s > 0) begin
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (s <= 8)
          set_size(CFG_DATA_W'(plan_rows[s-1]), CFG_DATA_W'(plan_cols[s-1]));
        else
          set_size(CFG_DATA_W'($urandom_range(1, MAX_ROWS)),
                   CFG_DATA_W'($urandom_range(1, MAX_COLS)));
      end
      hot_r = $urandom_range(0, gen_rows - 1);
      hot_c = $urandom_range(0, gen_cols - 1);
      ops_made = 0;
      while (ops_made < OPS_PER_SIZE / 2) random_op();
      // hold the sender until the first half has fully come back
      drain();
      while (ops_made < OPS_PER_SIZE) random_op();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("bilinear_gray_sampler_core: match");
    end else begin
      $display("bilinear_gray_sampler_core: mismatch");
    end
    $finish;
  end

endmodule
